### hw/rtl/cdq_pkg.sv
// ----------------------------------------------------------------------------
// cdq_pkg
// Shared types and codes for the circular deque: command and status codes,
// the stored entry and the packed command and response transactions.
// ----------------------------------------------------------------------------
package cdq_pkg;

	localparam int DefDepth = 128;

	typedef enum logic [2:0] {
		CMD_PUSH_BACK  = 3'd0,
		CMD_PUSH_FRONT = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_PEEK       = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_EMPTY    = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic signed [31:0] value;
	} entry_t;

	typedef struct packed {
		logic        [2:0]  cmd;
		logic signed [31:0] entry_key;
		logic signed [31:0] entry_value;
	} cmd_item_t;

	typedef struct packed {
		logic signed [31:0] front_key;
		logic signed [31:0] front_value;
		logic signed [31:0] back_key;
		logic signed [31:0] back_value;
		logic        [7:0]  entry_count;
		logic        [1:0]  status;
	} rsp_item_t;

endpackage

### hw/rtl/cdq_store.sv
// ----------------------------------------------------------------------------
// cdq_store
// Entry memory: one write port and two read ports (front and back), read data
// registered.
// ----------------------------------------------------------------------------
module cdq_store import cdq_pkg::*; #(
	parameter int DEPTH = DefDepth,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  entry_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr_front,
	input  logic [AW-1:0] rd_addr_back,
	output entry_t        rd_front,
	output entry_t        rd_back
);

	entry_t mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read front and back entries
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_front <= mem[rd_addr_front];
			rd_back  <= mem[rd_addr_back];
		end
	end

endmodule

### hw/rtl/cdq_ctrl.sv
// ----------------------------------------------------------------------------
// cdq_ctrl
// Deque sequencer: decodes a command, moves the front and back pointers and
// the count, writes a pushed entry, reads back the end entries and builds
// the response.
// ----------------------------------------------------------------------------
module cdq_ctrl import cdq_pkg::*; #(
	parameter int DEPTH = DefDepth,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic          clk,
	input  logic          arst_n,
	// command side
	input  logic          cmd_valid,
	output logic          cmd_stall,
	input  cmd_item_t     cmd_data,
	// memory side
	output logic          wr_en,
	output logic [AW-1:0] wr_addr,
	output entry_t        wr_data,
	output logic          rd_en,
	output logic [AW-1:0] rd_addr_front,
	output logic [AW-1:0] rd_addr_back,
	input  entry_t        rd_front,
	input  entry_t        rd_back,
	// response side
	input  logic          res_ready,
	output logic          res_valid,
	output rsp_item_t     res_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DONE
	} state_t;

	localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FullCnt = CW'(DEPTH);

	state_t          state_q;
	logic [AW-1:0]   front_q;
	logic [AW-1:0]   back_q;
	logic [CW-1:0]   count_q;
	status_t         status_q;

	logic            accept;
	logic            is_full;
	logic            is_empty;
	logic [AW-1:0]   front_inc;
	logic [AW-1:0]   front_dec;
	logic [AW-1:0]   back_inc;
	logic [AW-1:0]   back_dec;
	logic [AW-1:0]   front_nxt;
	logic [AW-1:0]   back_nxt;
	logic [CW-1:0]   count_nxt;
	status_t         status_nxt;
	logic            push_nxt;
	logic [CW+7:0]   count_ext;

	assign accept    = cmd_valid && (state_q == S_IDLE);
	assign cmd_stall = (state_q != S_IDLE);
	assign is_full   = (count_q == FullCnt);
	assign is_empty  = (count_q == '0);

	// Wrap the pointers around the store
	assign front_inc = (front_q == LastIdx) ? '0 : front_q + 1'b1;
	assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;
	assign back_inc  = (back_q == LastIdx) ? '0 : back_q + 1'b1;
	assign back_dec  = (back_q == '0) ? LastIdx : back_q - 1'b1;

	// Decode the command into next pointers, count and status
	always_comb begin
		front_nxt  = front_q;
		back_nxt   = back_q;
		count_nxt  = count_q;
		status_nxt = ST_OK;
		push_nxt   = 1'b0;
		unique case (cmd_data.cmd)
			CMD_PUSH_BACK: begin
				if (is_full) begin
					status_nxt = ST_OVERFLOW;
				end else begin
					back_nxt  = back_inc;
					count_nxt = count_q + 1'b1;
					push_nxt  = 1'b1;
				end
			end
			CMD_PUSH_FRONT: begin
				if (is_full) begin
					status_nxt = ST_OVERFLOW;
				end else begin
					front_nxt = front_dec;
					count_nxt = count_q + 1'b1;
					push_nxt  = 1'b1;
					if (is_empty) begin
						back_nxt = front_dec;
					end
				end
			end
			CMD_POP_FRONT: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					front_nxt = front_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			CMD_POP_BACK: begin
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					back_nxt  = back_dec;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
				// peek, and the unused codes act as peek
				if (is_empty) begin
					status_nxt = ST_EMPTY;
				end
			end
		endcase
	end

	// Write a pushed entry at its new end
	assign wr_en   = accept && push_nxt;
	assign wr_addr = (cmd_data.cmd == CMD_PUSH_BACK) ? back_inc : front_dec;
	assign wr_data = '{key: cmd_data.entry_key, value: cmd_data.entry_value};

	// Read both ends once the pointers have settled
	assign rd_en         = (state_q == S_READ);
	assign rd_addr_front = front_q;
	assign rd_addr_back  = back_q;

	// Build the response; an empty deque reports zero entries
	assign count_ext = {8'd0, count_q};
	always_comb begin
		res_valid            = (state_q == S_DONE) && res_ready;
		res_data.entry_count = count_ext[7:0];
		res_data.status      = status_q;
		if (is_empty) begin
			res_data.front_key   = '0;
			res_data.front_value = '0;
			res_data.back_key    = '0;
			res_data.back_value  = '0;
		end else begin
			res_data.front_key   = rd_front.key;
			res_data.front_value = rd_front.value;
			res_data.back_key    = rd_back.key;
			res_data.back_value  = rd_back.value;
		end
	end

	// Hold the sequencer state, pointers, count and status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= '0;
			back_q   <= LastIdx;
			count_q  <= '0;
			status_q <= ST_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						front_q  <= front_nxt;
						back_q   <= back_nxt;
						count_q  <= count_nxt;
						status_q <= status_nxt;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### hw/rtl/circular_deque.sv
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of key/value pairs in a circular entry memory.
// ----------------------------------------------------------------------------
// Each command first updates the pointers and writes a pushed entry, then
// reads the front and back entries through the registered memory read, and
// finally hands the response on to the output register. The
// next command is accepted as soon as the previous response sits in the
// output register, even while that register is stalled. Every command yields
// exactly one response with the front and back entries, the count and the
// status after the command; a push on a full deque is dropped with overflow
// status, a pop or peek on an empty deque returns empty status.
module circular_deque import cdq_pkg::*; #(
	parameter int DEPTH = DefDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  cmd_item_t cmd_data,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr_front;
	logic [AW-1:0] rd_addr_back;
	entry_t        rd_front;
	entry_t        rd_back;
	logic          res_ready;
	logic          res_valid;
	rsp_item_t     res_data;
	logic          rsp_valid_q;
	rsp_item_t     rsp_data_q;

	cdq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (cmd_valid),
		.cmd_stall     (cmd_stall),
		.cmd_data      (cmd_data),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr_front (rd_addr_front),
		.rd_addr_back  (rd_addr_back),
		.rd_front      (rd_front),
		.rd_back       (rd_back),
		.res_ready     (res_ready),
		.res_valid     (res_valid),
		.res_data      (res_data)
	);

	cdq_store #(.DEPTH(DEPTH)) u_store (
		.clk           (clk),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_en         (rd_en),
		.rd_addr_front (rd_addr_front),
		.rd_addr_back  (rd_addr_back),
		.rd_front      (rd_front),
		.rd_back       (rd_back)
	);

	// Take a new response when the output register is free or draining
	assign res_ready = !rsp_valid_q || !rsp_stall;

	// Hold the response transaction until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (res_valid) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_data_q <= res_data;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_data_q;

endmodule

### sim/circular_deque_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circular_deque_tb
// Self-checking testbench for the circular key/value deque. Commands go in
// through the valid/stall command channel while a local deque model predicts
// each response; every accepted response is compared field by field with the
// oldest prediction. Directed cases cover the empty and full edges, pointer
// wrap and the unused command codes, then biased random walks fill and drain
// the deque under three sender/receiver idling mixes.
// ----------------------------------------------------------------------------
module circular_deque_tb;
	import cdq_pkg::*;

	localparam int DEPTH = DefDepth;
	localparam int NUM_CODES = 8;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_item_t cmd_data = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_data;

	// Local copy of the deque contents and pointers
	entry_t deque_store [DEPTH];
	int     front_ptr = 0;
	int     back_ptr = DEPTH - 1;
	int     deque_count = 0;

	rsp_item_t rsp_expected [$];
	int        errors = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;

	circular_deque #(.DEPTH(DEPTH)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_data  (rsp_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Apply one command to the local deque and return the response it yields
	function automatic rsp_item_t apply_command(cmd_item_t item);
		rsp_item_t rsp;
		status_t   st;
		st = ST_OK;
		case (item.cmd)
			CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
				if (deque_count >= DEPTH) begin
					st = ST_OVERFLOW;
				end else if (item.cmd == CMD_PUSH_BACK) begin
					back_ptr = (back_ptr + 1) % DEPTH;
					deque_store[back_ptr] = entry_t'{key: item.entry_key, value: item.entry_value};
					deque_count++;
				end else begin
					front_ptr = (front_ptr + DEPTH - 1) % DEPTH;
					deque_store[front_ptr] = entry_t'{key: item.entry_key, value: item.entry_value};
					deque_count++;
					if (deque_count == 1)
						back_ptr = front_ptr;
				end
			end
			CMD_POP_FRONT: begin
				if (deque_count == 0) begin
					st = ST_EMPTY;
				end else begin
					front_ptr = (front_ptr + 1) % DEPTH;
					deque_count--;
				end
			end
			CMD_POP_BACK: begin
				if (deque_count == 0) begin
					st = ST_EMPTY;
				end else begin
					back_ptr = (back_ptr + DEPTH - 1) % DEPTH;
					deque_count--;
				end
			end
			default: begin
				// peek and the unused codes only report
				if (deque_count == 0)
					st = ST_EMPTY;
			end
		endcase
		rsp = '0;
		if (deque_count != 0) begin
			rsp.front_key   = deque_store[front_ptr].key;
			rsp.front_value = deque_store[front_ptr].value;
			rsp.back_key    = deque_store[back_ptr].key;
			rsp.back_value  = deque_store[back_ptr].value;
		end
		rsp.entry_count = deque_count[7:0];
		rsp.status      = st;
		return rsp;
	endfunction

	// Mostly random words, with the extremes mixed in
	function automatic logic [31:0] rand_word();
		case ($urandom_range(15))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'hFFFF_FFFF;
			3: return 32'h0000_0000;
			default: return $urandom;
		endcase
	endfunction

	// Drive one command transaction and record its prediction on acceptance
	task automatic send_cmd(input logic [2:0] op, input logic [31:0] k, input logic [31:0] v);
		cmd_item_t item;
		item.cmd         = op;
		item.entry_key   = k;
		item.entry_value = v;
		if ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		cmd_valid <= 1'b1;
		cmd_data  <= item;
		do @(posedge clk); while (cmd_stall);
		rsp_expected.push_back(apply_command(item));
	endtask

	task automatic set_idling(input int send_pct, input int recv_pct);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
	endtask

	task automatic compare_field(input string name, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, actual %0h", name, want_v, got_v);
			errors++;
		end
	endtask

	// Empty edge, unused codes, extreme keys and values, single-entry cases
	task automatic test_directed_edges();
		send_cmd(CMD_PEEK, 32'h0, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h1, 32'h2);
		send_cmd(CMD_POP_BACK, 32'h3, 32'h4);
		for (int c = CMD_PEEK + 1; c < NUM_CODES; c++)
			send_cmd(c[2:0], $urandom, $urandom);
		// front push from index zero wraps the front pointer
		send_cmd(CMD_PUSH_FRONT, 32'h7FFF_FFFF, 32'h8000_0000);
		send_cmd(CMD_PUSH_BACK, 32'h8000_0000, 32'h7FFF_FFFF);
		send_cmd(CMD_PUSH_BACK, 32'hFFFF_FFFF, 32'h0000_0000);
		send_cmd(CMD_PUSH_FRONT, 32'h0000_0000, 32'hFFFF_FFFF);
		send_cmd(CMD_PEEK, $urandom, $urandom);
		send_cmd(3'(NUM_CODES - 1), $urandom, $urandom);
		send_cmd(CMD_POP_BACK, 32'h0, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h0, 32'h0);
		send_cmd(CMD_POP_FRONT, 32'h0, 32'h0);
		send_cmd(CMD_POP_BACK, 32'h0, 32'h0);
		send_cmd(CMD_POP_BACK, 32'h0, 32'h0);
		// single entry from either end, removed from the other
		send_cmd(CMD_PUSH_FRONT, 32'h1234_5678, 32'h9ABC_DEF0);
		send_cmd(CMD_POP_BACK, 32'h0, 32'h0);
		send_cmd(CMD_PUSH_BACK, 32'hDEAD_BEEF, 32'h0BAD_F00D);
		send_cmd(CMD_POP_FRONT, 32'h0, 32'h0);
	endtask

	// Fill to full, push against the full deque, then drain past empty
	task automatic test_fill_overflow();
		while (deque_count < DEPTH)
			send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word(), rand_word());
		send_cmd(CMD_PUSH_BACK, rand_word(), rand_word());
		send_cmd(CMD_PUSH_FRONT, rand_word(), rand_word());
		send_cmd(CMD_PEEK, rand_word(), rand_word());
		send_cmd(3'($urandom_range(CMD_PEEK + 1, NUM_CODES - 1)), rand_word(), rand_word());
		send_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT, rand_word(), rand_word());
		while (deque_count > 0)
			send_cmd($urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK, rand_word(), rand_word());
		send_cmd(CMD_POP_FRONT, rand_word(), rand_word());
		send_cmd(CMD_POP_BACK, rand_word(), rand_word());
	endtask

	// Random walk in runs that lean toward filling or toward draining
	task automatic test_random_walk(input int num_cmds);
		int         push_pct;
		int         run_left;
		int         pick;
		logic [2:0] op;
		run_left = 0;
		push_pct = 50;
		for (int i = 0; i < num_cmds; i++) begin
			if (run_left == 0) begin
				push_pct = $urandom_range(1) ? 75 : 25;
				run_left = $urandom_range(10, 150);
			end
			run_left--;
			pick = $urandom_range(99);
			if (pick < 5)
				op = 3'($urandom_range(CMD_PEEK, NUM_CODES - 1));
			else if ($urandom_range(99) < push_pct)
				op = $urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
			else
				op = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
			send_cmd(op, rand_word(), rand_word());
		end
	endtask

	// Check each response transaction and drive the receiver stall
	always @(posedge clk) begin : rsp_check
		rsp_item_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_expected.size() == 0) begin
				$error("response with no command outstanding");
				errors++;
			end else begin
				want = rsp_expected.pop_front();
				compare_field("front_key", want.front_key, rsp_data.front_key);
				compare_field("front_value", want.front_value, rsp_data.front_value);
				compare_field("back_key", want.back_key, rsp_data.back_key);
				compare_field("back_value", want.back_value, rsp_data.back_value);
				compare_field("entry_count", 32'(want.entry_count),
					32'(rsp_data.entry_count));
				compare_field("status", 32'(want.status), 32'(rsp_data.status));
			end
		end
		rsp_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	initial begin
		int drain_cycles;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_idling(26, 49);
		test_directed_edges();
		test_fill_overflow();
		test_random_walk(400);

		set_idling(49, 26);
		test_fill_overflow();
		test_random_walk(400);

		set_idling(0, 0);
		test_fill_overflow();
		test_random_walk(400);

		// drop valid and wait for the outstanding responses
		cmd_valid <= 1'b0;
		drain_cycles = 0;
		while (rsp_expected.size() != 0 && drain_cycles < 10000) begin
			@(posedge clk);
			drain_cycles++;
		end
		if (rsp_expected.size() != 0) begin
			$error("%0d responses never arrived", rsp_expected.size());
			errors++;
		end
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Stop a hung run
	initial begin
		#10ms;
		$display("FAIL");
		$finish;
	end

endmodule
